>>> sv/rmf_pkg.sv
// Shared types and constants for the RGB 3x3 median filter.
// Used by rgb_median_filter_3x3_unit; depends on nothing else.
package rmf_pkg;

    localparam int SAMPLE_PORT_BITS = 8;
    localparam int CFG_INDEX_BITS   = 1;
    localparam int CFG_DATA_BITS    = 10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                     opcode;
        logic [SAMPLE_PORT_BITS-1:0] red_in;
        logic [SAMPLE_PORT_BITS-1:0] green_in;
        logic [SAMPLE_PORT_BITS-1:0] blue_in;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_PORT_BITS-1:0] red_out;
        logic [SAMPLE_PORT_BITS-1:0] green_out;
        logic [SAMPLE_PORT_BITS-1:0] blue_out;
        logic                        frame_end;
    } out_t;

    // Per-word window control, computed at accept time
    typedef struct packed {
        logic emit;
        logic frame_end;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } ctl_t;

endpackage

>>> sv/rmf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// A read of the address being written returns the old contents. No dependencies.
module rmf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/rgb_median_filter_3x3_unit.sv
// Streaming 3x3 median filter on RGB pixels, top level.
// Depends on rmf_pkg and rmf_ram (line buffer).
//
// Pixels arrive in raster order, one word per clock; the block takes a new word
// every cycle while its 4-entry result queue has room. The result for pixel k leaves
// with the word that carries pixel k+width+1, via the stage 1 and stage 2 registers.
// After a frame, width+1 drain words flush the remaining results (for a single-row
// frame, width drain words, and the block holds off input at frame end while it
// steps the line buffer). The line buffer is one RAM of MAX_LINE entries,
// each holding two earlier rows of one column; every word reads its column and
// writes it back in the next cycle, with forwarding when the next word hits the same
// column (one-pixel-wide frames). No clearing pass is needed after reset.
module rgb_median_filter_3x3_unit #(
    parameter int MAX_LINE    = 512,
    parameter int MAX_ROWS    = 512,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rmf_pkg::in_t                         s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rmf_pkg::out_t                        m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rmf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rmf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import rmf_pkg::*;

    localparam int STORE_BITS = (SAMPLE_BITS < SAMPLE_PORT_BITS) ? SAMPLE_BITS
                                                                  : SAMPLE_PORT_BITS;
    localparam int PIX_BITS   = 3 * STORE_BITS;
    localparam int LINE_BITS  = 2 * PIX_BITS;
    localparam int ADDR_BITS  = $clog2(MAX_LINE);
    localparam int WCNT_BITS  = ADDR_BITS + 1;
    localparam int ROW_BITS   = $clog2(MAX_ROWS + 2);
    localparam int W_RESET    = (MAX_LINE < 512) ? MAX_LINE : 512;
    localparam int H_RESET    = (MAX_ROWS < 512) ? MAX_ROWS : 512;
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FCNT_BITS  = $clog2(FIFO_DEPTH + 1);

    // Effective frame size and input position
    logic [WCNT_BITS-1:0] eff_w_reg, eff_w_next;
    logic [ROW_BITS-1:0]  eff_h_reg, eff_h_next;
    logic [ADDR_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0]  row_reg, row_next;
    logic                 auto_reg, auto_next;

    logic                 cfg_fire, in_fire, complete;
    logic                 act_pixel, act_drain, act, col_wrap;
    logic [WCNT_BITS-1:0] col_inc;
    ctl_t                 ctl0;
    logic [PIX_BITS-1:0]  pix_in;

    // Stage 1: line buffer data returns
    logic                 s1_valid_reg;
    logic                 s1_fwd_reg;
    logic [ADDR_BITS-1:0] s1_addr_reg;
    logic [PIX_BITS-1:0]  s1_pix_reg;
    ctl_t                 s1_ctl_reg;
    logic [LINE_BITS-1:0] ram_rdata, line_word, fwd_data_reg, wr_data;
    logic [2:0][PIX_BITS-1:0] col_now, col_p1_reg, col_p2_reg;
    logic [8:0][PIX_BITS-1:0] win;
    logic [8:0]               win_ok;
    logic [2:0]               row_ok, colm_ok;

    // Stage 2: median select
    logic                     s2_valid_reg;
    logic                     s2_fend_reg;
    logic [8:0][PIX_BITS-1:0] s2_win_reg;
    logic [8:0]               s2_ok_reg;
    logic [8:0][STORE_BITS-1:0] red_v, green_v, blue_v;
    out_t                     res;

    // Result queue
    out_t                 fifo_reg [FIFO_DEPTH];
    logic [FPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_BITS-1:0] fcnt_reg, fcnt_next, pend;
    logic                 push, pop;

    function automatic logic [STORE_BITS-1:0] median_sel(
        input logic [8:0][STORE_BITS-1:0] v,
        input logic [8:0]                 ok
    );
        logic [3:0]            cnt;
        logic [3:0]            mid;
        logic [3:0]            rank;
        logic [STORE_BITS-1:0] sel;
        cnt = 4'($countones(ok));
        mid = cnt >> 1;
        sel = '0;
        // Rank each valid element, ties broken by position; pick rank count/2
        for (int i = 0; i < 9; i++) begin
            rank = '0;
            for (int j = 0; j < 9; j++) begin
                if (ok[j] && (j != i) && ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i)))) begin
                    rank = rank + 4'd1;
                end
            end
            if (ok[i] && (rank == mid)) begin
                sel = v[i];
            end
        end
        return sel;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_valid && s_ready;

    assign pend    = FCNT_BITS'(s1_valid_reg && s1_ctl_reg.emit) + FCNT_BITS'(s2_valid_reg);
    assign s_ready = !auto_reg && ((fcnt_reg + pend) < FCNT_BITS'(FIFO_DEPTH));

    // Configuration: clamp to the supported range
    always_comb begin
        eff_w_next = eff_w_reg;
        eff_h_next = eff_h_reg;
        if (cfg_fire) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: begin
                    if (cfg_data == '0) begin
                        eff_w_next = WCNT_BITS'(1);
                    end else if (32'(cfg_data) > 32'(MAX_LINE)) begin
                        eff_w_next = WCNT_BITS'(MAX_LINE);
                    end else begin
                        eff_w_next = WCNT_BITS'(cfg_data);
                    end
                end
                REG_FRAME_HEIGHT: begin
                    if (cfg_data == '0) begin
                        eff_h_next = ROW_BITS'(1);
                    end else if (32'(cfg_data) > 32'(MAX_ROWS)) begin
                        eff_h_next = ROW_BITS'(MAX_ROWS);
                    end else begin
                        eff_h_next = ROW_BITS'(cfg_data);
                    end
                end
            endcase
        end
    end

    // Stage 0: classify the word and work out which window taps are inside the image.
    // Drain words continue the position past the last row as virtual pixels.
    always_comb begin
        complete  = row_reg >= eff_h_reg;
        act_pixel = in_fire && (s_data.opcode == OP_PIXEL) && !complete;
        act_drain = in_fire && (s_data.opcode == OP_DRAIN) && complete;
        act       = act_pixel || act_drain || auto_reg;
        col_inc   = WCNT_BITS'(col_reg) + WCNT_BITS'(1);
        col_wrap  = col_inc >= eff_w_reg;

        ctl0.right_ok  = col_reg != '0;
        ctl0.left_ok   = (col_reg >= ADDR_BITS'(2))
                      || ((col_reg == '0) && (eff_w_reg >= WCNT_BITS'(2)));
        ctl0.top_ok    = (col_reg != '0) ? (row_reg >= ROW_BITS'(2))
                                         : (row_reg >= ROW_BITS'(3));
        ctl0.bot_ok    = (col_reg != '0) ? (row_reg < eff_h_reg)
                                         : (row_reg <= eff_h_reg);
        ctl0.emit      = (row_reg >= ROW_BITS'(2))
                      || ((row_reg == ROW_BITS'(1)) && (col_reg != '0));
        ctl0.frame_end = (row_reg == (eff_h_reg + ROW_BITS'(1))) && (col_reg == '0);

        pix_in = {s_data.red_in[STORE_BITS-1:0],
                  s_data.green_in[STORE_BITS-1:0],
                  s_data.blue_in[STORE_BITS-1:0]};

        row_next  = row_reg;
        col_next  = col_reg;
        // A single-row frame needs one extra step before the first drain result
        auto_next = act_pixel && col_wrap && (eff_h_reg == ROW_BITS'(1));
        priority if (cfg_fire) begin
            row_next = '0;
            col_next = '0;
        end else if (act) begin
            if (ctl0.frame_end) begin
                row_next = '0;
                col_next = '0;
            end else if (col_wrap) begin
                row_next = row_reg + ROW_BITS'(1);
                col_next = '0;
            end else begin
                col_next = col_inc[ADDR_BITS-1:0];
            end
        end
    end

    rmf_ram #(
        .WIDTH(LINE_BITS),
        .DEPTH(MAX_LINE)
    ) u_line_ram (
        .aclk   (aclk),
        .wr_en  (s1_valid_reg),
        .wr_addr(s1_addr_reg),
        .wr_data(wr_data),
        .rd_en  (act),
        .rd_addr(col_reg),
        .rd_data(ram_rdata)
    );

    // Stage 1: column = {two rows above from the line buffer, new pixel}
    always_comb begin
        line_word  = s1_fwd_reg ? fwd_data_reg : ram_rdata;
        col_now[0] = line_word[LINE_BITS-1:PIX_BITS];
        col_now[1] = line_word[PIX_BITS-1:0];
        col_now[2] = s1_pix_reg;
        wr_data    = {col_now[1], s1_pix_reg};

        row_ok  = {s1_ctl_reg.bot_ok, 1'b1, s1_ctl_reg.top_ok};
        colm_ok = {s1_ctl_reg.right_ok, 1'b1, s1_ctl_reg.left_ok};
        for (int r = 0; r < 3; r++) begin
            win[r*3]       = col_p2_reg[r];
            win[r*3 + 1]   = col_p1_reg[r];
            win[r*3 + 2]   = col_now[r];
            for (int c = 0; c < 3; c++) begin
                win_ok[r*3 + c] = row_ok[r] & colm_ok[c];
            end
        end
    end

    // Stage 2: per-channel median
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            red_v[i]   = s2_win_reg[i][2*STORE_BITS +: STORE_BITS];
            green_v[i] = s2_win_reg[i][STORE_BITS +: STORE_BITS];
            blue_v[i]  = s2_win_reg[i][0 +: STORE_BITS];
        end
        res.red_out   = SAMPLE_PORT_BITS'(median_sel(red_v, s2_ok_reg));
        res.green_out = SAMPLE_PORT_BITS'(median_sel(green_v, s2_ok_reg));
        res.blue_out  = SAMPLE_PORT_BITS'(median_sel(blue_v, s2_ok_reg));
        res.frame_end = s2_fend_reg;
    end

    assign push    = s2_valid_reg;
    assign pop     = m_valid && m_ready;
    assign m_valid = fcnt_reg != '0;
    assign m_data  = fifo_reg[rd_ptr_reg];

    always_comb begin
        unique case ({push, pop})
            2'b10:   fcnt_next = fcnt_reg + FCNT_BITS'(1);
            2'b01:   fcnt_next = fcnt_reg - FCNT_BITS'(1);
            default: fcnt_next = fcnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg    <= WCNT_BITS'(W_RESET);
            eff_h_reg    <= ROW_BITS'(H_RESET);
            row_reg      <= '0;
            col_reg      <= '0;
            auto_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fcnt_reg     <= '0;
        end else begin
            eff_w_reg    <= eff_w_next;
            eff_h_reg    <= eff_h_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            auto_reg     <= auto_next;
            s1_valid_reg <= act;
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
            fcnt_reg     <= fcnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FPTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (act) begin
            s1_addr_reg <= col_reg;
            s1_pix_reg  <= pix_in;
            s1_ctl_reg  <= ctl0;
            // Forward when the word ahead writes back the column we are reading
            s1_fwd_reg  <= s1_valid_reg && (s1_addr_reg == col_reg);
        end
        if (s1_valid_reg) begin
            fwd_data_reg <= wr_data;
            col_p2_reg   <= col_p1_reg;
            col_p1_reg   <= col_now;
            s2_win_reg   <= win;
            s2_ok_reg    <= win_ok;
            s2_fend_reg  <= s1_ctl_reg.frame_end;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= FCNT_BITS'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ((fcnt_reg < FCNT_BITS'(FIFO_DEPTH)) || pop))
        else $error("result pushed into a full queue");

    a_auto_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        auto_reg |-> !s_ready)
        else $error("input taken during line buffer step");

    a_fwd_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_fwd_reg) |-> ($past(s1_valid_reg)
            && (s1_addr_reg == $past(s1_addr_reg))))
        else $error("forwarding without a matching write ahead");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (act && ctl0.frame_end) |=> ((row_reg == '0) && (col_reg == '0)))
        else $error("position not cleared after last result of frame");
`endif

endmodule
